### rtl/cubemap_face_address_generator_top_defines.svh
// assertion macros for the address pipeline of the cubemap face address generator rtl
`ifndef CUBEMAP_FACE_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define CUBEMAP_FACE_ADDRESS_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define CFAG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define CFAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CFAG_ASSERT_NOW(label, clk, rst, ante, cons)
`define CFAG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/cfag_pkg.sv
// types, constants and cell tables for the cubemap face address generator
package cfag_pkg;

   // layout codes as reported on the result channel
   typedef enum logic [2:0] {
      LAYOUT_HSTRIP = 3'd0,
      LAYOUT_VSTRIP = 3'd1,
      LAYOUT_HCROSS = 3'd2,
      LAYOUT_VCROSS = 3'd3,
      LAYOUT_NONE   = 3'd4
   } layout_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // face codes
   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   // largest supported image side in pixels
   localparam logic [16:0] MAX_SIDE = 17'd16384;

   // field widths
   localparam int SIDE_W   = 15;
   localparam int COORD_W  = 14;
   localparam int FACE_W   = 3;
   localparam int CELL_W   = 3;
   localparam int PIX_W    = 18;
   localparam int OFFSET_W = 30;

   // classification of the configured image, constant between writes
   typedef struct packed {
      layout_type          layout;
      logic [SIDE_W-1:0]   face_size;
   } cls_type;

   // cell column of a face, in units of the face size
   function automatic logic [CELL_W-1:0] cell_col(layout_type lay, logic [FACE_W-1:0] face);
      logic [CELL_W-1:0] c;
      c = '0;
      case (lay)
         LAYOUT_HSTRIP: c = face;
         LAYOUT_VSTRIP: c = '0;
         LAYOUT_HCROSS, LAYOUT_VCROSS: begin
            case (face)
               FACE_POS_X: c = 3'd2;
               FACE_NEG_X: c = 3'd0;
               FACE_POS_Y: c = 3'd1;
               FACE_NEG_Y: c = 3'd1;
               FACE_POS_Z: c = 3'd1;
               FACE_NEG_Z: c = (lay == LAYOUT_HCROSS) ? 3'd3 : 3'd1;
               default:    c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   // cell row of a face, in units of the face size
   function automatic logic [CELL_W-1:0] cell_row(layout_type lay, logic [FACE_W-1:0] face);
      logic [CELL_W-1:0] r;
      r = '0;
      case (lay)
         LAYOUT_HSTRIP: r = '0;
         LAYOUT_VSTRIP: r = face;
         LAYOUT_HCROSS, LAYOUT_VCROSS: begin
            case (face)
               FACE_POS_X: r = 3'd1;
               FACE_NEG_X: r = 3'd1;
               FACE_POS_Y: r = 3'd0;
               FACE_NEG_Y: r = 3'd2;
               FACE_POS_Z: r = 3'd1;
               FACE_NEG_Z: r = (lay == LAYOUT_HCROSS) ? 3'd1 : 3'd3;
               default:    r = '0;
            endcase
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/cfag_class.sv
// layout classifier: picks layout and face size from the configured image size
module cfag_class
   import cfag_pkg::*;
(
   input  logic [SIDE_W-1:0] image_width,
   input  logic [SIDE_W-1:0] image_height,
   output cls_type           cls
);

   logic [17:0] w6;
   logic [17:0] h6;
   logic [17:0] w3;
   logic [17:0] h3;
   logic [17:0] w4;
   logic [17:0] h4;
   logic [17:0] w_ext;
   logic [17:0] h_ext;
   logic        oversize;
   layout_type  lay;
   logic [SIDE_W-1:0] fs;

   // scaled sides; w/6 == h with w%6 == 0 is the same as w == 6h, and so on
   always_comb begin
      w_ext = {3'b000, image_width};
      h_ext = {3'b000, image_height};
      w4    = {1'b0, image_width, 2'b00};
      h4    = {1'b0, image_height, 2'b00};
      w3    = w4 - w_ext;
      h3    = h4 - h_ext;
      w6    = {w3[16:0], 1'b0};
      h6    = {h3[16:0], 1'b0};
      oversize = ({2'b00, image_width} > MAX_SIDE) || ({2'b00, image_height} > MAX_SIDE);
   end

   // layouts in priority order
   always_comb begin
      lay = LAYOUT_NONE;
      fs  = '0;
      if (!oversize) begin
         if (w_ext == h6) begin
            lay = LAYOUT_HSTRIP;
            fs  = image_height;
         end else if (h_ext == w6) begin
            lay = LAYOUT_VSTRIP;
            fs  = image_width;
         end else if (w3 == h4) begin
            lay = LAYOUT_HCROSS;
            fs  = {2'b00, image_width[SIDE_W-1:2]};
         end else if (w4 == h3) begin
            lay = LAYOUT_VCROSS;
            fs  = {2'b00, image_height[SIDE_W-1:2]};
         end
      end
      // a face side of zero is unsupported
      if (fs == '0) begin
         lay = LAYOUT_NONE;
      end
      cls.layout    = lay;
      cls.face_size = fs;
   end

endmodule

### rtl/cfag_pipe.sv
// five-stage address pipeline: capture, check with cell lookup, cell origin, row product, sum
`include "cubemap_face_address_generator_top_defines.svh"
module cfag_pipe
   import cfag_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [FACE_W-1:0]   face,
   input  logic [COORD_W-1:0]  row,
   input  logic [COORD_W-1:0]  col,
   input  cls_type             cls,
   input  logic [SIDE_W-1:0]   image_width,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OFFSET_W-1:0] byte_offset,
   output logic [2:0]          layout,
   output logic [SIDE_W-1:0]   face_size,
   output logic                error
);

   localparam int SUM_W = OFFSET_W - 2;
   localparam int PROD_W = PIX_W + SIDE_W;

   // stage valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: captured item
   logic [FACE_W-1:0]  face1_ff;
   logic [COORD_W-1:0] row1_ff;
   logic [COORD_W-1:0] col1_ff;

   // stage 2: checked item with cell origin
   layout_type         lay2_ff,  lay2_in;
   logic [SIDE_W-1:0]  fs2_ff,   fs2_in;
   logic               err2_ff,  err2_in;
   logic [CELL_W-1:0]  crow2_ff, crow2_in;
   logic [CELL_W-1:0]  ccol2_ff, ccol2_in;
   logic [COORD_W-1:0] row2_ff;
   logic [COORD_W-1:0] col2_ff;

   // stage 3: pixel row and column in the source image
   layout_type         lay3_ff;
   logic [SIDE_W-1:0]  fs3_ff;
   logic               err3_ff;
   logic [PIX_W-1:0]   prow3_ff, prow3_in;
   logic [PIX_W-1:0]   pcol3_ff, pcol3_in;

   // stage 4: row times width
   layout_type         lay4_ff;
   logic [SIDE_W-1:0]  fs4_ff;
   logic               err4_ff;
   logic [SUM_W-1:0]   prod4_ff, prod4_in;
   logic [PIX_W-1:0]   pcol4_ff;
   logic [PROD_W-1:0]  prod_full;

   // stage 5: output register
   layout_type          lay5_ff;
   logic [SIDE_W-1:0]   fs5_ff;
   logic                err5_ff;
   logic [OFFSET_W-1:0] off5_ff, off5_in;
   logic [SUM_W-1:0]    sum4;

   // ready chain from the output back to the input
   always_comb begin
      rdy5 = !v5_ff || rsp_tready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      v5_in = rdy5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (rdy1) begin
         face1_ff <= face;
         row1_ff  <= row;
         col1_ff  <= col;
      end
   end

   // range checks and cell lookup
   always_comb begin
      lay2_in  = cls.layout;
      fs2_in   = cls.face_size;
      err2_in  = (cls.layout == LAYOUT_NONE) || (face1_ff > FACE_NEG_Z)
               || ({1'b0, row1_ff} >= cls.face_size)
               || ({1'b0, col1_ff} >= cls.face_size);
      crow2_in = cell_row(cls.layout, face1_ff);
      ccol2_in = cell_col(cls.layout, face1_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         lay2_ff  <= lay2_in;
         fs2_ff   <= fs2_in;
         err2_ff  <= err2_in;
         crow2_ff <= crow2_in;
         ccol2_ff <= ccol2_in;
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
      end
   end

   // cell origin plus position inside the face
   always_comb begin
      prow3_in = ({{(PIX_W-CELL_W){1'b0}}, crow2_ff} * {{(PIX_W-SIDE_W){1'b0}}, fs2_ff})
               + {{(PIX_W-COORD_W){1'b0}}, row2_ff};
      pcol3_in = ({{(PIX_W-CELL_W){1'b0}}, ccol2_ff} * {{(PIX_W-SIDE_W){1'b0}}, fs2_ff})
               + {{(PIX_W-COORD_W){1'b0}}, col2_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         lay3_ff  <= lay2_ff;
         fs3_ff   <= fs2_ff;
         err3_ff  <= err2_ff;
         prow3_ff <= prow3_in;
         pcol3_ff <= pcol3_in;
      end
   end

   // row times image width, kept to the bits the offset needs
   always_comb begin
      prod_full = {{SIDE_W{1'b0}}, prow3_ff} * {{PIX_W{1'b0}}, image_width};
      prod4_in  = prod_full[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         lay4_ff  <= lay3_ff;
         fs4_ff   <= fs3_ff;
         err4_ff  <= err3_ff;
         prod4_ff <= prod4_in;
         pcol4_ff <= pcol3_ff;
      end
   end

   // add column, scale to bytes, zero on error
   always_comb begin
      sum4    = prod4_ff + {{(SUM_W-PIX_W){1'b0}}, pcol4_ff};
      off5_in = err4_ff ? '0 : {sum4, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         lay5_ff <= lay4_ff;
         fs5_ff  <= fs4_ff;
         err5_ff <= err4_ff;
         off5_ff <= off5_in;
      end
   end

   // result channel
   assign req_tready  = rdy1;
   assign rsp_tvalid  = v5_ff;
   assign byte_offset = off5_ff;
   assign layout      = lay5_ff;
   assign face_size   = fs5_ff;
   assign error       = err5_ff;

   `CFAG_ASSERT_NOW(a_err_zero_offset, clock, reset, v5_ff && err5_ff, off5_ff == '0)
   `CFAG_ASSERT_NOW(a_none_is_error, clock, reset, v5_ff && (lay5_ff == LAYOUT_NONE),
                    err5_ff && (fs5_ff == '0))
   `CFAG_ASSERT_NOW(a_ok_has_face, clock, reset, v5_ff && !err5_ff,
                    (lay5_ff != LAYOUT_NONE) && (fs5_ff != '0))
   `CFAG_ASSERT_NEXT(a_stage3_holds, clock, reset, v3_ff && !rdy4,
                     v3_ff && $stable(prow3_ff) && $stable(pcol3_ff))

endmodule

### rtl/cubemap_face_address_generator_top.sv
// cubemap face address generator top level: config registers and stream packing
//
//   channel  direction  tdata (low bit up)              tuser
//   req      in         row[13:0] col[27:14]            face[2:0]
//   rsp      out        byte_offset[29:0] face_size[44:30]  layout[2:0] error[3]
//   csr      in         csr_index 0 width, 1 height, csr_wdata[14:0]
//
// one item per cycle sustained while rsp_tready stays high, result valid from the output register
// the five register stages are capture, range check with cell lookup, cell origin,
// row product, and sum with the output register
// backpressure stalls each stage only while its successor is full, so bubbles close up
// reset clears all stage valid bits and both size registers to zero
// the row product is one 18 by 15 multiplier ahead of stage four
module cubemap_face_address_generator_top
   import cfag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request item stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row[13:0], col[27:14], zero pad
   input  logic [2:0]  req_tuser,   // face[2:0]
   // result item stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // byte_offset[29:0], face_size[44:30], zero pad
   output logic [3:0]  rsp_tuser,   // layout[2:0], error[3]
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   logic [SIDE_W-1:0]   width_ff,  width_in;
   logic [SIDE_W-1:0]   height_ff, height_in;
   cls_type             cls;
   logic [OFFSET_W-1:0] byte_offset;
   logic [2:0]          layout;
   logic [SIDE_W-1:0]   face_size;
   logic                error;

   // configuration register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // layout classifier
   cfag_class u_class (
      .image_width  (width_ff),
      .image_height (height_ff),
      .cls          (cls)
   );

   // address pipeline
   cfag_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .face        (req_tuser[2:0]),
      .row         (req_tdata[13:0]),
      .col         (req_tdata[27:14]),
      .cls         (cls),
      .image_width (width_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .byte_offset (byte_offset),
      .layout      (layout),
      .face_size   (face_size),
      .error       (error)
   );

   // result packing
   assign rsp_tdata = {3'b000, face_size, byte_offset};
   assign rsp_tuser = {error, layout};

endmodule
